// File: rtl/assert_macros.svh
// Assertion macros for the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge out of reset
`define PSCS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pscs assertion failed");
// next-cycle implication
`define PSCS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pscs assertion failed");
`else
`define PSCS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PSCS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/pscs_pkg.sv
// Package: types, constants and the logistic table of the sodium conductance step
package pscs_pkg;

  // logistic table geometry (power of two, 64 to 4096)
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int TABLE_HALF  = TABLE_DEPTH / 2;
  localparam int IDX_SHIFT   = 28 - IDX_W;

  // datapath widths
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int DIFF_W    = 19;
  localparam int PROD_W    = 40;
  localparam int IDXF_W    = PROD_W + 1;
  localparam int RP_W      = 34;
  localparam int NP_W      = 19;
  localparam int CUR_W     = 52;

  // 10 mV junction offset in 1/256 mV
  localparam logic signed [DIFF_W-1:0] JUNCTION_OFFSET = 19'sd2560;

  // index clamp bounds
  localparam logic signed [IDXF_W-1:0] IDX_LO   = '0;
  localparam logic signed [IDXF_W-1:0] IDX_HI   = IDXF_W'(TABLE_DEPTH - 1);
  localparam logic signed [IDXF_W-1:0] IDX_MID  = IDXF_W'(TABLE_HALF);
  localparam logic [IDX_W-1:0]         IDX_TOP  = IDX_W'(TABLE_DEPTH - 1);

  // divide-by-65535 correction threshold
  localparam logic [33:0] FRAC_DIV = 34'd65535;
  localparam logic [31:0] FRAC_RND = 32'd32767;

  // current rounding and saturation
  localparam logic signed [CUR_W-1:0] CUR_RND = CUR_W'(64'd1 << 27);
  localparam logic signed [CUR_W-1:0] CUR_POS = CUR_W'(1048575);
  localparam logic signed [CUR_W-1:0] CUR_NEG = -CUR_W'(1048576);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REVERSAL  = 3'd0,
    REG_MAX_COND  = 3'd1,
    REG_MAX_FRAC  = 3'd2,
    REG_HALF_ACT  = 3'd3,
    REG_INV_SLOPE = 3'd4,
    REG_RELAX     = 3'd5
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SLOPE,
    ST_INDEX,
    ST_ROM,
    ST_MUL_MAX,
    ST_DIV,
    ST_FIX,
    ST_MUL_RELAX,
    ST_UPDATE,
    ST_MUL_COND,
    ST_MUL_DRIVE,
    ST_OUT
  } pscs_state_e;

  // controller to datapath step strobes
  typedef struct packed {
    logic load_in;
    logic mul_slope;
    logic index;
    logic rom_rd;
    logic mul_max;
    logic div;
    logic fix;
    logic mul_relax;
    logic update;
    logic mul_cond;
    logic mul_drive;
    logic load_out;
  } pscs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } pscs_sts_t;

  typedef logic [TABLE_DEPTH-1:0][15:0] rom_t;

  // ---- elaboration-time table build (Q62 fixed point) ----
  localparam logic [63:0] ONE_Q62  = 64'd1 << 62;
  localparam logic [63:0] ROM_STEP = (ONE_Q62 / 64'(TABLE_DEPTH)) * 64'd16;

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // shift-subtract long division
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t sig_rom_build();
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] m;
    logic [63:0] pw [14];
    rom_t        rom;
    term = ONE_Q62;
    sum  = ONE_Q62;
    // exp(-step) by its series
    for (int k = 1; k <= 30; k++) begin
      term = udiv64(mul_q62(term, ROM_STEP), 64'(k));
      if (k % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    pw[0] = sum;
    for (int k = 1; k < 14; k++) begin
      pw[k] = mul_q62(pw[k-1], pw[k-1]);
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i >= TABLE_HALF) m = 64'(i - TABLE_HALF);
      else                 m = 64'(TABLE_HALF - i);
      e = ONE_Q62;
      for (int k = 0; k < 14; k++) begin
        if (m[k]) e = mul_q62(e, pw[k]);
      end
      d = (ONE_Q62 + e) >> 20;
      if (i >= TABLE_HALF) num = 64'd65535 << 42;
      else                 num = 64'd65535 * (e >> 20);
      rom[i] = 16'(udiv64(num + (d >> 1), d));
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = sig_rom_build();

endpackage

// File: rtl/pscs_ctrl.sv
// Sequencer: steps one sample through the shared datapath
module pscs_ctrl import pscs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pscs_sts_t sts_i,
  output pscs_cmd_t cmd_o
);

  pscs_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and step strobes
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MUL_SLOPE;
        end
      end
      ST_MUL_SLOPE: begin
        cmd_o.mul_slope = 1'b1;
        state_d         = ST_INDEX;
      end
      ST_INDEX: begin
        cmd_o.index = 1'b1;
        state_d     = ST_ROM;
      end
      ST_ROM: begin
        cmd_o.rom_rd = 1'b1;
        state_d      = ST_MUL_MAX;
      end
      ST_MUL_MAX: begin
        cmd_o.mul_max = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_MUL_RELAX;
      end
      ST_MUL_RELAX: begin
        cmd_o.mul_relax = 1'b1;
        state_d         = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_MUL_COND;
      end
      ST_MUL_COND: begin
        cmd_o.mul_cond = 1'b1;
        state_d        = ST_MUL_DRIVE;
      end
      ST_MUL_DRIVE: begin
        cmd_o.mul_drive = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        // wait until the output register is free
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pscs_datapath.sv
// Datapath: config registers, gating arithmetic, fraction state, output register
module pscs_datapath import pscs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DAT_W-1:0]        cfg_data_i,
  input  logic signed [16:0]          membrane_voltage_i,
  input  logic                        out_ready_i,
  input  pscs_cmd_t                   cmd_i,
  output pscs_sts_t                   sts_o,
  output logic                        out_valid_o,
  output logic signed [20:0]          injected_current_o,
  output logic [15:0]                 open_fraction_o
);

  // configuration
  logic signed [16:0] rev_q;
  logic [15:0]        gmax_q;
  logic [15:0]        pmax_q;
  logic signed [16:0] half_q;
  logic [19:0]        slope_q;
  logic [15:0]        relax_q;

  // state and handshake
  logic [15:0] frac_q, frac_d;
  logic        out_valid_q;

  // payload registers
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [DIFF_W-1:0] rdiff_q, rdiff_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [15:0]              rom_q;
  logic [31:0]              pm_q, pm_d;
  logic [16:0]              q0_q, q0_d;
  logic [15:0]              pinf_q, pinf_d;
  logic signed [RP_W-1:0]   rp_q, rp_d;
  logic [31:0]              gp_q, gp_d;
  logic signed [CUR_W-1:0]  cur_q, cur_d;
  logic signed [20:0]       current_q, current_d;
  logic [15:0]              frac_out_q;

  // intermediates
  logic signed [DIFF_W-1:0] v_ext;
  logic signed [PROD_W-1:0] scaled;
  logic signed [IDXF_W-1:0] idx_full;
  logic [32:0]              div_sum;
  logic [33:0]              rem;
  logic signed [16:0]       delta;
  logic signed [RP_W-1:0]   rp_sh;
  logic signed [NP_W-1:0]   np;
  logic signed [NP_W-1:0]   pmax_s;
  logic signed [CUR_W-1:0]  rnd;
  logic signed [CUR_W-1:0]  shr;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q   <= 17'sd14080;
      gmax_q  <= 16'd0;
      pmax_q  <= 16'd65535;
      half_q  <= -17'sd11750;
      slope_q <= 20'd20480;
      relax_q <= 16'd31890;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_REVERSAL:  rev_q   <= $signed(cfg_data_i[16:0]);
        REG_MAX_COND:  gmax_q  <= cfg_data_i[15:0];
        REG_MAX_FRAC:  pmax_q  <= cfg_data_i[15:0];
        REG_HALF_ACT:  half_q  <= $signed(cfg_data_i[16:0]);
        REG_INV_SLOPE: slope_q <= cfg_data_i;
        REG_RELAX:     relax_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // junction-corrected voltage differences
  assign v_ext   = DIFF_W'(membrane_voltage_i);
  assign diff_d  = v_ext - JUNCTION_OFFSET - DIFF_W'(half_q);
  assign rdiff_d = DIFF_W'(rev_q) - v_ext + JUNCTION_OFFSET;

  // scaled distance from half activation
  assign prod_d = PROD_W'(diff_q * $signed({1'b0, slope_q}));

  // table index, clamped at both ends
  assign scaled   = prod_q >>> IDX_SHIFT;
  assign idx_full = IDXF_W'(scaled) + IDX_MID;
  always_comb begin
    if (idx_full < IDX_LO)      idx_d = '0;
    else if (idx_full > IDX_HI) idx_d = IDX_TOP;
    else                        idx_d = idx_full[IDX_W-1:0];
  end

  // pmax * table value, rounded for the divide by 65535
  assign pm_d = (pmax_q * rom_q) + FRAC_RND;

  // quotient estimate, then one correction step
  assign div_sum = {1'b0, pm_q} + {17'd0, pm_q[31:16]};
  assign q0_d    = div_sum[32:16];
  assign rem     = {2'b0, pm_q} + {17'd0, q0_q} - {1'b0, q0_q, 16'd0};
  assign pinf_d  = (rem >= FRAC_DIV) ? 16'(q0_q + 17'd1) : q0_q[15:0];

  // relaxation step toward the steady state
  assign delta = $signed({1'b0, pinf_q}) - $signed({1'b0, frac_q});
  assign rp_d  = RP_W'(delta * $signed({1'b0, relax_q}));

  assign rp_sh  = rp_q >>> 16;
  assign np     = NP_W'($signed({1'b0, frac_q})) + NP_W'(rp_sh);
  assign pmax_s = $signed({3'b0, pmax_q});
  always_comb begin
    if (np > pmax_s)              frac_d = pmax_q;
    else if (np < NP_W'(0))       frac_d = 16'd0;
    else                          frac_d = np[15:0];
  end

  // conductance and driving force
  assign gp_d  = gmax_q * frac_q;
  assign cur_d = CUR_W'($signed({1'b0, gp_q}) * rdiff_q);

  // round, scale and saturate the current
  assign rnd = cur_q + CUR_RND;
  assign shr = rnd >>> 28;
  always_comb begin
    if (shr > CUR_POS)      current_d = CUR_POS[20:0];
    else if (shr < CUR_NEG) current_d = CUR_NEG[20:0];
    else                    current_d = shr[20:0];
  end

  // fraction state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q      <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) frac_q <= frac_d;
      if (cmd_i.load_out)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // step registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      diff_q  <= diff_d;
      rdiff_q <= rdiff_d;
    end
    if (cmd_i.mul_slope) prod_q <= prod_d;
    if (cmd_i.index)     idx_q  <= idx_d;
    if (cmd_i.rom_rd)    rom_q  <= SIG_ROM[idx_q];
    if (cmd_i.mul_max)   pm_q   <= pm_d;
    if (cmd_i.div)       q0_q   <= q0_d;
    if (cmd_i.fix)       pinf_q <= pinf_d;
    if (cmd_i.mul_relax) rp_q   <= rp_d;
    if (cmd_i.mul_cond)  gp_q   <= gp_d;
    if (cmd_i.mul_drive) cur_q  <= cur_d;
    if (cmd_i.load_out) begin
      current_q  <= current_d;
      frac_out_q <= frac_q;
    end
  end

  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign injected_current_o = current_q;
  assign open_fraction_o   = frac_out_q;

endmodule

// File: rtl/persistent_sodium_conductance_step.sv
// Top level: persistent sodium conductance update per membrane-voltage sample
//
//   channel   | handshake               | payload
//   ----------+-------------------------+------------------------------------------
//   config    | cfg_we_i                | cfg_index_i[2:0], cfg_data_i[19:0]
//   sample in | in_valid_i / in_ready_o | membrane_voltage_i[16:0]
//   result    | out_valid_o / out_ready_i | injected_current_o[20:0], open_fraction_o
//
// The sequencer walks the shared datapath one multiply or table read a step and
// takes a new sample only once the previous result has gone into the output
// register. Reset clears the fraction state, loads the register defaults,
// empties the output. A result held by out_ready_i low parks the sequencer in
// its last step; the next sample is still taken while a finished result waits.
`include "assert_macros.svh"

module persistent_sodium_conductance_step import pscs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [16:0]   membrane_voltage_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [20:0]   injected_current_o,
  output logic [15:0]          open_fraction_o
);

  pscs_cmd_t cmd;
  pscs_sts_t sts;

  // sequencer
  pscs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  pscs_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .membrane_voltage_i (membrane_voltage_i),
    .out_ready_i        (out_ready_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .injected_current_o (injected_current_o),
    .open_fraction_o    (open_fraction_o)
  );

  // checks
  `PSCS_ASSERT_NXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `PSCS_ASSERT_IMP(a_no_result_overwrite, clk_i, rst_ni, cmd.load_out, sts.out_free)
  `PSCS_ASSERT_IMP(a_one_step_at_a_time, clk_i, rst_ni, 1'b1, $onehot0(cmd))
  `PSCS_ASSERT_NXT(a_result_shown, clk_i, rst_ni, cmd.load_out, out_valid_o)

endmodule

// File: dv/tb_top.sv
// Testbench for the persistent sodium conductance step: predictor, scoreboard and stimulus
module tb_top;
  import pscs_pkg::*;

  // 10 mV junction offset in 1/256 mV
  localparam longint OFFSET_LSB  = 2560;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     REPORT_MAX  = 10;

  // writes to these indexes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam cfg_reg_e REG_ORDER [6] = '{REG_REVERSAL, REG_MAX_COND, REG_MAX_FRAC,
                                         REG_HALF_ACT, REG_INV_SLOPE, REG_RELAX};

  typedef logic [CFG_DAT_W-1:0] reg_set_t [6];

  typedef struct packed {
    logic signed [20:0] current;
    logic [15:0]        fraction;
  } result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_e;

  // ---------------------------------------------------------------------------
  // Scoreboard: own conductance predictor plus the queue of predicted results
  // ---------------------------------------------------------------------------
  class conductance_scoreboard;
    longint rev_mv, g_max, p_max, v_half, k_slope, relax, frac;
    logic [15:0] logistic_rom [TABLE_DEPTH];
    result_t predicted_results [$];
    int errors;

    function new();
      errors = 0;
      build_logistic();
      rev_mv  = 14080;
      g_max   = 0;
      p_max   = 65535;
      v_half  = -11750;
      k_slope = 20480;
      relax   = 31890;
      frac    = 0;
    endfunction

    // (a*b) >> 62, unsigned Q62 product
    function longint unsigned q62_product(longint unsigned a, longint unsigned b);
      logic [127:0] wide;
      wide = 128'(a) * 128'(b);
      return wide[125:62];
    endfunction

    // logistic table over x in [-8,8): exp(-step) by series, then binary powers
    function void build_logistic();
      longint unsigned one, step, term, total, e, d, num, m;
      longint unsigned pw [14];
      longint off;
      one   = 64'd1 << 62;
      step  = (one / 64'(TABLE_DEPTH)) * 64'd16;
      term  = one;
      total = one;
      for (int k = 1; k <= 30; k++) begin
        term = q62_product(term, step) / 64'(k);
        if (k % 2 == 1) total = total - term;
        else            total = total + term;
      end
      pw[0] = total;
      for (int k = 1; k < 14; k++) pw[k] = q62_product(pw[k-1], pw[k-1]);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        off = longint'(i) - TABLE_DEPTH / 2;
        m   = (off < 0) ? -off : off;
        e   = one;
        for (int k = 0; k < 14; k++) begin
          if (m[k]) e = q62_product(e, pw[k]);
        end
        d = (one + e) >> 20;
        if (off >= 0) num = 64'd65535 << 42;
        else          num = 64'd65535 * (e >> 20);
        logistic_rom[i] = 16'((num + d / 2) / d);
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_REVERSAL:  rev_mv  = longint'($signed(data[16:0]));
        REG_MAX_COND:  g_max   = longint'(data[15:0]);
        REG_MAX_FRAC:  p_max   = longint'(data[15:0]);
        REG_HALF_ACT:  v_half  = longint'($signed(data[16:0]));
        REG_INV_SLOPE: k_slope = longint'(data[19:0]);
        REG_RELAX:     relax   = longint'(data[15:0]);
        default: ;
      endcase
    endfunction

    // accepted sample: advance the fraction and queue the predicted result
    function void note_sample(logic signed [16:0] v);
      longint vc, prod, idx, pinf, p, amps;
      result_t r;
      vc   = longint'(v) - OFFSET_LSB;
      prod = (vc - v_half) * k_slope;
      idx  = ((prod * TABLE_DEPTH) >>> 28) + TABLE_DEPTH / 2;
      if (idx < 0) idx = 0;
      if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
      pinf = (p_max * longint'(logistic_rom[idx]) + 32767) / 65535;
      // relax toward steady state, floor shift, clamp to [0, p_max]
      p = frac + (((pinf - frac) * relax) >>> 16);
      if (p > p_max) p = p_max;
      if (p < 0) p = 0;
      frac = p;
      // driving force on the corrected voltage, rounded and saturated
      amps = g_max * p * (rev_mv - vc);
      amps = (amps + (longint'(1) << 27)) >>> 28;
      if (amps > 1048575) amps = 1048575;
      if (amps < -1048576) amps = -1048576;
      r.current  = 21'(amps);
      r.fraction = 16'(p);
      predicted_results.push_back(r);
    endfunction

    function void check_result(logic signed [20:0] amps, logic [15:0] fraction);
      result_t want;
      if (predicted_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: current %0d fraction %0d", amps, fraction);
        return;
      end
      want = predicted_results.pop_front();
      if (want.current !== amps || want.fraction !== fraction) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: current exp %0d got %0d, fraction exp %0d got %0d",
                   want.current, amps, want.fraction, fraction);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals and DUT
  // ---------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic signed [16:0]   membrane_voltage_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [20:0]   injected_current_o;
  logic [15:0]          open_fraction_o;

  conductance_scoreboard sb = new();
  int     cycle_count = 0;
  stall_e stall_mode  = STALL_NONE;
  int     stall_left  = 0;

  persistent_sodium_conductance_step DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .membrane_voltage_i (membrane_voltage_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .injected_current_o (injected_current_o),
    .open_fraction_o    (open_fraction_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // monitor: every transfer on either channel goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(injected_current_o, open_fraction_o);
      if (in_valid_i && in_ready_o) sb.note_sample(membrane_voltage_i);
    end
  end

  // receiver: stall pattern picks a new random mode whenever its countdown runs out
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(32, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_ready_i <= 1'b1;
      STALL_COIN:  out_ready_i <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_ready_i <= ($urandom_range(0, 7) == 0);
      default:     out_ready_i <= (stall_left % 5 != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Driver tasks (all start and end on a rising edge)
  // ---------------------------------------------------------------------------
  // valid stays high on return so a burst continues without a drop
  task automatic drive_sample(input logic signed [16:0] v);
    in_valid_i         <= 1'b1;
    membrane_voltage_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // hold off the sender until every predicted result has been seen
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.predicted_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_settings(input reg_set_t vals, input bit spare);
    logic [CFG_IDX_W-1:0] spare_idx [2];
    spare_idx = '{REG_SPARE_A, REG_SPARE_B};
    wait_drained();
    for (int r = 0; r < 6; r++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= REG_ORDER[r];
      cfg_data_i  <= vals[r];
      sb.write_reg(REG_ORDER[r], vals[r]);
      @(posedge clk_i);
    end
    // unknown indexes with garbage data: must leave every register alone
    if (spare) begin
      for (int r = 0; r < 2; r++) begin
        cfg_index_i <= spare_idx[r];
        cfg_data_i  <= CFG_DAT_W'($urandom);
        sb.write_reg(spare_idx[r], cfg_data_i);
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random value pickers
  // ---------------------------------------------------------------------------
  function automatic logic [CFG_DAT_W-1:0] pick_millivolt_reg();
    int val;
    logic [CFG_DAT_W-1:0] d;
    case ($urandom_range(0, 5))
      0:       val = -51200;
      1:       val = 51200;
      default: val = int'($urandom_range(0, 102400)) - 51200;
    endcase
    d = CFG_DAT_W'(val);
    d[CFG_DAT_W-1:17] = 3'($urandom);
    return d;
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_q16_reg();
    logic [CFG_DAT_W-1:0] d;
    case ($urandom_range(0, 5))
      0:       d = '0;
      1:       d = 20'd65535;
      default: d = CFG_DAT_W'($urandom_range(0, 65535));
    endcase
    d[CFG_DAT_W-1:16] = 4'($urandom);
    return d;
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_slope_reg();
    case ($urandom_range(0, 9))
      0:       return 20'd1;
      1:       return 20'd1048575;
      2:       return 20'd0;
      default: return CFG_DAT_W'($urandom_range(1, (1 << $urandom_range(4, 20)) - 1));
    endcase
  endfunction

  function automatic void pick_settings(output reg_set_t s);
    s[REG_REVERSAL]  = pick_millivolt_reg();
    s[REG_MAX_COND]  = pick_q16_reg();
    s[REG_MAX_FRAC]  = pick_q16_reg();
    s[REG_HALF_ACT]  = pick_millivolt_reg();
    s[REG_INV_SLOPE] = pick_slope_reg();
    s[REG_RELAX]     = pick_q16_reg();
  endfunction

  // half the samples land in the steep part of the current logistic
  function automatic logic signed [16:0] pick_voltage();
    longint span, v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        span = (sb.k_slope == 0) ? 51200 : (longint'(1) << 27) / sb.k_slope;
        if (span > 51200) span = 51200;
        if (span < 1) span = 1;
        v = sb.v_half + OFFSET_LSB + longint'($urandom_range(0, 32'(2 * span))) - span;
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
      end
      9:       v = longint'($signed(17'($urandom)));
      default: v = longint'($urandom_range(0, 102400)) - 51200;
    endcase
    return 17'(v);
  endfunction

  task automatic run_random(input int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) burst = left;
      repeat (burst) drive_sample(pick_voltage());
      left -= burst;
      case ($urandom_range(0, 15))
        0:             wait_drained();
        1, 2, 3, 4, 5: ;
        default:       pause_sender($urandom_range(1, 20));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    reg_set_t settings;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= '0;
    cfg_data_i         <= '0;
    in_valid_i         <= 1'b0;
    membrane_voltage_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, zero conductance, field extremes
    drive_sample(-17'sd51200);
    drive_sample(17'sd51200);
    drive_sample(17'sd0);
    drive_sample(-17'sd65536);
    drive_sample(17'sd65535);

    // full conductance, steep slope, instant relaxation: positive saturation
    settings = '{20'd51200, 20'd65535, 20'd65535, CFG_DAT_W'(-51200), 20'd1048575, 20'd65535};
    load_settings(settings, 1'b0);
    drive_sample(17'sd51200);
    drive_sample(-17'sd40000);
    drive_sample(-17'sd51200);
    drive_sample(-17'sd40000);

    // low reversal potential: negative saturation, index clamped at both ends
    settings = '{CFG_DAT_W'(-51200), 20'd65535, 20'd65535, CFG_DAT_W'(-51200), 20'd1048575,
                 20'd65535};
    load_settings(settings, 1'b0);
    drive_sample(17'sd51200);
    drive_sample(-17'sd65536);
    drive_sample(17'sd65535);

    // zero inverse slope: middle entry whatever the voltage
    settings = '{20'd14080, 20'd40000, 20'd65535, 20'd0, 20'd0, 20'd32768};
    load_settings(settings, 1'b1);
    drive_sample(17'sd0);
    drive_sample(17'sd51200);
    drive_sample(-17'sd51200);

    // maximum lowered below the held fraction, frozen relaxation
    settings = '{20'd14080, 20'd40000, 20'd1000, 20'd0, 20'd20480, 20'd0};
    load_settings(settings, 1'b1);
    drive_sample(17'sd0);
    drive_sample(-17'sd12345);

    // zero maximum fraction
    settings = '{20'd51200, 20'd65535, 20'd0, 20'd0, 20'd20480, 20'd65535};
    load_settings(settings, 1'b0);
    drive_sample(17'sd100);
    drive_sample(-17'sd100);

    // random settings, bursts of samples per setting
    for (int ph = 0; ph < 7; ph++) begin
      pick_settings(settings);
      load_settings(settings, 1'($urandom_range(0, 1)));
      run_random(80);
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.predicted_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/pscs_pkg.sv
rtl/pscs_ctrl.sv
rtl/pscs_datapath.sv
rtl/persistent_sodium_conductance_step.sv
dv/tb_top.sv
